>>> src/i2p_pkg.sv
// shared types, character codes and helper functions of the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int DEF_STACK_DEPTH = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_OPEN  = 2'd2,
    ERR_OVF   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_PUSH,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OP,
    MODE_FLUSH
  } mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       expr_end;
  } infix_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       run_last;
    logic       expr_done;
    err_t       error_code;
  } postfix_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) p = 2'd2;
    else if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

>>> src/infix_to_postfix_converter.sv
// top level of the infix to postfix converter
`timescale 1ns / 1ps

// Converts an infix expression, one ASCII character per item on the infix
// channel, into postfix characters on the postfix channel (shunting yard).
// Mark the final character with expr_end; its last result item carries
// expr_done and the error code, and is an empty item (has_char = 0) when
// nothing else is produced. run_last marks the last result of each item.
// Steps of an item: accept, any looks at the stack top (a read, then a compare,
// since the stack memory has a registered read port), a push where needed,
// and a final step. An operator or close paren looks once per popped entry,
// plus once more unless the stack runs empty; the final flush looks once per
// popped operator and once at an open paren that stops it. One item is worked
// on at a time; infix_stall is high while it is in progress. A popped
// character or a letter is held back as pending so that run_last can be set;
// it enters the output register at the next pop or at the final step. A
// stalled postfix channel holds its item; the sequencer waits for the output
// register to free and then continues, and the next infix item can be taken
// while the final result still waits there.
// Reset empties the stack and clears the error state; stack contents need
// no clearing pass.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              infix_valid,
  output logic              infix_stall,
  input  i2p_pkg::infix_t   infix_item,
  output logic              postfix_valid,
  input  logic              postfix_stall,
  output i2p_pkg::postfix_t postfix_item
);

  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;
  logic          out_free;
  logic          res_load;
  postfix_t      res_item;

  i2p_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (infix_valid),
    .in_stall   (infix_stall),
    .in_item    (infix_item),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_item   (res_item)
  );

  i2p_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  i2p_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .load_item(res_item),
    .free     (out_free),
    .valid    (postfix_valid),
    .stall    (postfix_stall),
    .item     (postfix_item)
  );

endmodule

>>> src/i2p_stack_mem.sv
// operator stack storage: one write port, one registered read port
`timescale 1ns / 1ps

module i2p_stack_mem #(
  parameter int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/i2p_out_reg.sv
// output register of the postfix channel
`timescale 1ns / 1ps

module i2p_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  i2p_pkg::postfix_t load_item,
  output logic              free,
  output logic              valid,
  input  logic              stall,
  output i2p_pkg::postfix_t item
);

  import i2p_pkg::*;

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      item <= load_item;
    end
  end

endmodule

>>> src/i2p_ctrl.sv
// sequencer: classifies characters, pops and pushes the stack, builds result items
`timescale 1ns / 1ps

module i2p_ctrl #(
  parameter int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2p_pkg::infix_t   in_item,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output logic [7:0]        mem_wr_data,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  logic [7:0]        mem_rd_data,
  input  logic              out_free,
  output logic              res_load,
  output i2p_pkg::postfix_t res_item
);

  import i2p_pkg::*;

  state_t     state, state_next;
  mode_t      mode, mode_next;
  logic [CW-1:0] count, count_next;
  err_t       err, err_next;
  logic [7:0] char_q;
  logic       last_q;
  logic       pend_valid, pend_valid_next;
  logic [7:0] pend_char, pend_char_next;

  logic       accept;
  logic       last_now;
  logic       chk_emit;
  logic       go_flush;
  logic [7:0] top;
  logic [7:0] c;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign c        = in_item.char_in;
  assign last_now = (state == S_IDLE) ? in_item.expr_end : last_q;
  assign top      = mem_rd_data;

  // top of stack leaves when it outranks or ties, or is anything but the open paren
  always_comb begin
    unique case (mode)
      MODE_OP: chk_emit = prec_of(top) >= prec_of(char_q);
      default: chk_emit = (top != CH_LPAR);
    endcase
  end

  assign go_flush = last_now && (err_next == ERR_NONE) && (count_next != '0);

  // next state
  always_comb begin
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (err != ERR_NONE) begin
            state_next = S_FIN;
          end else if (c == CH_LPAR || (prec_of(c) != 2'd0 && count == '0)) begin
            state_next = S_PUSH;
          end else if (c == CH_RPAR && count != '0) begin
            state_next = S_RD;
            mode_next  = MODE_CLOSE;
          end else if (prec_of(c) != 2'd0) begin
            state_next = S_RD;
            mode_next  = MODE_OP;
          end else if (go_flush) begin
            state_next = S_RD;
            mode_next  = MODE_FLUSH;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (out_free) begin
          if (chk_emit) begin
            if (count != CW'(1)) state_next = S_RD;
            else if (mode == MODE_OP) state_next = S_PUSH;
            else state_next = S_FIN;
          end else begin
            unique case (mode)
              MODE_OP: state_next = S_PUSH;
              MODE_CLOSE: begin
                if (go_flush) begin
                  state_next = S_RD;
                  mode_next  = MODE_FLUSH;
                end else begin
                  state_next = S_FIN;
                end
              end
              default: state_next = S_FIN;
            endcase
          end
        end
      end
      S_PUSH: begin
        if (go_flush) begin
          state_next = S_RD;
          mode_next  = MODE_FLUSH;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next      = count;
    err_next        = err;
    pend_valid_next = pend_valid;
    pend_char_next  = pend_char;
    res_load        = 1'b0;
    res_item        = '0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = count[AW-1:0];
    mem_wr_data     = char_q;
    mem_rd_en       = (state == S_RD);
    mem_rd_addr     = AW'(count - CW'(1));
    unique case (state)
      S_IDLE: begin
        if (accept && err == ERR_NONE) begin
          if (is_alnum(c)) begin
            pend_valid_next = 1'b1;
            pend_char_next  = c;
          end else if (c == CH_RPAR && count == '0) begin
            err_next = ERR_CLOSE;
          end
        end
      end
      S_CHK: begin
        if (out_free) begin
          if (chk_emit) begin
            // an earlier pending char is now known not to be the last one
            if (pend_valid) begin
              res_load          = 1'b1;
              res_item.char_out = pend_char;
              res_item.has_char = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = top;
            count_next      = count - CW'(1);
            if (count == CW'(1) && mode == MODE_CLOSE) err_next = ERR_CLOSE;
          end else begin
            unique case (mode)
              MODE_CLOSE: count_next = count - CW'(1);
              MODE_FLUSH: err_next = ERR_OPEN;
              default: ;
            endcase
          end
        end
      end
      S_PUSH: begin
        if (count >= CW'(STACK_DEPTH)) begin
          err_next = ERR_OVF;
        end else begin
          mem_wr_en  = 1'b1;
          count_next = count + CW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_load            = pend_valid || last_q;
          res_item.char_out   = pend_valid ? pend_char : 8'd0;
          res_item.has_char   = pend_valid;
          res_item.run_last   = 1'b1;
          res_item.expr_done  = last_q;
          res_item.error_code = last_q ? err : ERR_NONE;
          pend_valid_next     = 1'b0;
          if (last_q) begin
            count_next = '0;
            err_next   = ERR_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= MODE_OP;
      count      <= '0;
      err        <= ERR_NONE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      count      <= count_next;
      err        <= err_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_char <= pend_char_next;
    if (accept) begin
      char_q <= in_item.char_in;
      last_q <= in_item.expr_end;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> count != '0)
    else $error("stack read while empty");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("pending char left over between items");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free && last_q) |=> (count == '0 && err == ERR_NONE))
    else $error("stack or error not cleared at end of expression");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_CHK) |-> $past(state) == S_RD)
    else $error("stack top used without a read");

endmodule

>>> test/infix_to_postfix_converter_tb.sv
// self-checking testbench of the infix to postfix converter: directed table, then random expressions
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int STK_DEPTH   = DEF_STACK_DEPTH;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SYM_TARGET  = 350;

  typedef struct {
    infix_t   item;
    bit       pinned;
    postfix_t res;
  } row_t;

  logic     clk;
  logic     rst;
  logic     infix_valid;
  logic     infix_stall;
  infix_t   infix_item;
  logic     postfix_valid;
  logic     postfix_stall;
  postfix_t postfix_item;

  // predictor state
  logic [7:0] op_stk [STK_DEPTH];
  int         stk_cnt;
  err_t       err_lat;
  postfix_t   step_out [STK_DEPTH + 2];
  int         step_n;

  row_t     offer_q [$];
  postfix_t postfix_expect_q [$];
  row_t     directed_rows [$];
  int       mismatches;
  int       quiet_cycles;
  int       sym_sent;
  int       hold_req;
  bit       idle_on;

  infix_to_postfix_converter dut (
    .clk          (clk),
    .rst          (rst),
    .infix_valid  (infix_valid),
    .infix_stall  (infix_stall),
    .infix_item   (infix_item),
    .postfix_valid(postfix_valid),
    .postfix_stall(postfix_stall),
    .postfix_item (postfix_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int op_rank(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS:         return 1;
      CH_STAR, CH_SLASH, CH_PCT: return 2;
      CH_CARET:                  return 3;
      default:                   return 0;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function void emit_char(input logic [7:0] c, input bit has);
    postfix_t r;
    r.char_out   = has ? c : 8'h00;
    r.has_char   = has;
    r.run_last   = 1'b0;
    r.expr_done  = 1'b0;
    r.error_code = ERR_NONE;
    step_out[step_n] = r;
    step_n++;
  endfunction

  function void pop_emit();
    stk_cnt--;
    emit_char(op_stk[stk_cnt], 1'b1);
  endfunction

  function void push_op(input logic [7:0] c);
    if (stk_cnt >= STK_DEPTH) begin
      err_lat = ERR_OVF;
    end else begin
      op_stk[stk_cnt] = c;
      stk_cnt++;
    end
  endfunction

  // shunting yard step for one character, results land in step_out
  function void shunt_step(input infix_t it);
    logic [7:0] c;
    c = it.char_in;
    step_n = 0;
    if (err_lat == ERR_NONE) begin
      if (c == CH_SPACE || c == CH_TAB) begin
      end else if (is_operand(c)) begin
        emit_char(c, 1'b1);
      end else if (c == CH_LPAR) begin
        push_op(c);
      end else if (c == CH_RPAR) begin
        while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CH_LPAR) pop_emit();
        if (stk_cnt > 0) stk_cnt--;
        else err_lat = ERR_CLOSE;
      end else if (op_rank(c) > 0) begin
        while (stk_cnt > 0 && op_rank(op_stk[stk_cnt - 1]) >= op_rank(c)) pop_emit();
        push_op(c);
      end
      if (it.expr_end && err_lat == ERR_NONE) begin
        while (stk_cnt > 0 && op_stk[stk_cnt - 1] != CH_LPAR) pop_emit();
        if (stk_cnt > 0) err_lat = ERR_OPEN;
      end
    end
    if (it.expr_end) begin
      if (step_n == 0) emit_char(8'h00, 1'b0);
      step_out[step_n - 1].expr_done  = 1'b1;
      step_out[step_n - 1].error_code = err_lat;
      stk_cnt = 0;
      err_lat = ERR_NONE;
    end
    if (step_n > 0) step_out[step_n - 1].run_last = 1'b1;
  endfunction

  function automatic postfix_t one_res(input logic [7:0] c, input bit has, input bit done,
                                       input err_t err);
    postfix_t r;
    r.char_out   = c;
    r.has_char   = has;
    r.run_last   = 1'b1;
    r.expr_done  = done;
    r.error_code = err;
    return r;
  endfunction

  function void add_row(input logic [7:0] c, input bit e, input bit pin, input postfix_t res);
    row_t r;
    r.item.char_in  = c;
    r.item.expr_end = e;
    r.pinned        = pin;
    r.res           = res;
    directed_rows.push_back(r);
  endfunction

  // monitor: predict on accepted infix items, check accepted postfix items
  always @(posedge clk) begin
    row_t     r;
    postfix_t exp_res;
    if (!rst) begin
      if ((infix_valid && !infix_stall) || (postfix_valid && !postfix_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (postfix_valid && !postfix_stall) begin
        if (postfix_expect_q.size() == 0) begin
          $error("unexpected result item char_out=%h has_char=%b", postfix_item.char_out,
                 postfix_item.has_char);
          mismatches++;
        end else begin
          exp_res = postfix_expect_q.pop_front();
          if (postfix_item.char_out !== exp_res.char_out) begin
            $error("char_out: expected %h, got %h", exp_res.char_out, postfix_item.char_out);
            mismatches++;
          end
          if (postfix_item.has_char !== exp_res.has_char) begin
            $error("has_char: expected %b, got %b", exp_res.has_char, postfix_item.has_char);
            mismatches++;
          end
          if (postfix_item.run_last !== exp_res.run_last) begin
            $error("run_last: expected %b, got %b", exp_res.run_last, postfix_item.run_last);
            mismatches++;
          end
          if (postfix_item.expr_done !== exp_res.expr_done) begin
            $error("expr_done: expected %b, got %b", exp_res.expr_done, postfix_item.expr_done);
            mismatches++;
          end
          if (postfix_item.error_code !== exp_res.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_res.error_code,
                   postfix_item.error_code);
            mismatches++;
          end
        end
      end
      if (infix_valid && !infix_stall) begin
        r = offer_q.pop_front();
        shunt_step(infix_item);
        if (r.pinned) begin
          postfix_expect_q.push_back(r.res);
        end else begin
          for (int i = 0; i < step_n; i++) postfix_expect_q.push_back(step_out[i]);
        end
      end
    end
  end

  // receiver: random stalls per item, plus one long hold on request
  initial begin
    int n;
    postfix_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = idle_on ? $urandom_range(0, 5) : 0;
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        postfix_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      postfix_stall <= 1'b0;
      do @(posedge clk); while (!postfix_valid);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_row(input row_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      infix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offer_q.push_back(r);
    infix_item  <= r.item;
    infix_valid <= 1'b1;
    do @(posedge clk); while (infix_stall);
    sym_sent++;
  endtask

  task automatic send_expr(input logic [7:0] chars [$], input bit close_it);
    row_t r;
    r.pinned = 1'b0;
    r.res    = '0;
    for (int i = 0; i < chars.size(); i++) begin
      r.item.char_in  = chars[i];
      r.item.expr_end = close_it && (i == chars.size() - 1);
      send_row(r);
    end
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PCT;
      default: return CH_CARET;
    endcase
  endfunction

  initial begin
    logic [7:0] chars [$];
    int         len;
    int         depth;
    int         kind;
    bit         hold_done;
    rst           = 1'b1;
    infix_valid   = 1'b0;
    infix_item    = '0;
    mismatches    = 0;
    quiet_cycles  = 0;
    sym_sent      = 0;
    hold_req      = 0;
    hold_done     = 1'b0;
    idle_on       = 1'b1;
    stk_cnt       = 0;
    err_lat       = ERR_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // precedence, every operator, blanks, byte extremes and the unmatched close and open paren errors
    add_row("a",      1'b0, 1'b1, one_res("a", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_PLUS,  1'b0, 1'b0, '0);
    add_row("Z",      1'b0, 1'b1, one_res("Z", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_STAR,  1'b0, 1'b0, '0);
    add_row("9",      1'b0, 1'b1, one_res("9", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_CARET, 1'b0, 1'b0, '0);
    add_row("0",      1'b0, 1'b1, one_res("0", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_PCT,   1'b0, 1'b0, '0);
    add_row("z",      1'b0, 1'b1, one_res("z", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_SLASH, 1'b0, 1'b0, '0);
    add_row("A",      1'b0, 1'b1, one_res("A", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_MINUS, 1'b0, 1'b0, '0);
    add_row(CH_LPAR,  1'b0, 1'b0, '0);
    add_row("b",      1'b0, 1'b1, one_res("b", 1'b1, 1'b0, ERR_NONE));
    add_row(CH_RPAR,  1'b0, 1'b0, '0);
    add_row(CH_TAB,   1'b0, 1'b0, '0);
    add_row(CH_SPACE, 1'b0, 1'b0, '0);
    add_row(8'h80,    1'b0, 1'b0, '0);
    add_row(8'hFF,    1'b1, 1'b0, '0);
    add_row(CH_RPAR,  1'b1, 1'b1, one_res(8'h00, 1'b0, 1'b1, ERR_CLOSE));
    add_row(CH_LPAR,  1'b1, 1'b1, one_res(8'h00, 1'b0, 1'b1, ERR_OPEN));
    add_row(8'h00,    1'b1, 1'b1, one_res(8'h00, 1'b0, 1'b1, ERR_NONE));
    add_row(CH_RPAR,  1'b0, 1'b0, '0);
    add_row("x",      1'b0, 1'b0, '0);
    add_row("y",      1'b1, 1'b1, one_res(8'h00, 1'b0, 1'b1, ERR_CLOSE));
    foreach (directed_rows[i]) send_row(directed_rows[i]);

    while (sym_sent < SYM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      // block the receiver for a long stretch while items keep coming
      if (!hold_done && sym_sent > SYM_TARGET / 2) begin
        hold_req  = HOLD_CYCLES;
        hold_done = 1'b1;
        idle_on   = 1'b0;
      end
      chars.delete();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // well-formed expression with random nesting and blanks
        len   = $urandom_range(1, 8);
        depth = 0;
        for (int i = 0; i < len; i++) begin
          while ($urandom_range(0, 3) == 0 && depth < 6) begin
            chars.push_back(CH_LPAR);
            depth++;
          end
          if ($urandom_range(0, 5) == 0) chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
          chars.push_back(rand_operand());
          while (depth > 0 && $urandom_range(0, 2) == 0) begin
            chars.push_back(CH_RPAR);
            depth--;
          end
          if (i < len - 1) chars.push_back(rand_op());
        end
        repeat (depth) chars.push_back(CH_RPAR);
        send_expr(chars, 1'b1);
      end else if (kind == 6) begin
        // deep nesting around the stack limit, overflow when past it
        len = $urandom_range(STK_DEPTH - 4, STK_DEPTH + 2);
        repeat (len) chars.push_back(CH_LPAR);
        chars.push_back(rand_operand());
        repeat (len) chars.push_back(CH_RPAR);
        send_expr(chars, 1'b1);
      end else if (kind < 9) begin
        // broken expression from a pool of awkward characters
        len = $urandom_range(1, 10);
        repeat (len) begin
          case ($urandom_range(0, 7))
            0:       chars.push_back(rand_operand());
            1:       chars.push_back(rand_op());
            2:       chars.push_back(CH_LPAR);
            3, 4:    chars.push_back(CH_RPAR);
            5:       chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            6:       chars.push_back(8'($urandom_range(0, 255)));
            default: chars.push_back(8'($urandom_range(128, 255)));
          endcase
        end
        send_expr(chars, $urandom_range(0, 3) != 0);
      end else begin
        chars.push_back(8'($urandom_range(0, 255)));
        send_expr(chars, $urandom_range(0, 1) != 0);
      end
    end
    // close any open expression so every result is drained
    chars.delete();
    chars.push_back(CH_SPACE);
    send_expr(chars, 1'b1);
    infix_valid <= 1'b0;

    while (postfix_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/i2p_pkg.sv
src/i2p_stack_mem.sv
src/i2p_out_reg.sv
src/i2p_ctrl.sv
src/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
